// ===== src/smte_pkg.sv =====
package smte_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FRAME_W     = 2 * SAMPLE_W;
    localparam int TAP_W       = 5;
    localparam int DELAY_W     = 21;
    localparam int SUM_W       = 21;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 21;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_HISTORY_DEPTH = 32768;
    localparam int DEF_MAX_TAPS      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACING    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALTERNATE_POL  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_DIVISOR = 4'd3;

    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_DRY  = 2'd1;
    localparam logic [1:0] SRC_MEM  = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_HI = 21'sd32767;
    localparam logic signed [SUM_W-1:0] SUM_LO = -21'sd32768;

    // ceil(2^21 / d), indexed by divisor d for d of 2 and up; entries 0 and 1 are zero
    localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
        21'd0,      21'd0,      21'd1048576, 21'd699051,
        21'd524288, 21'd419431, 21'd349526,  21'd299594,
        21'd262144, 21'd233017, 21'd209716,  21'd190651,
        21'd174763, 21'd161320, 21'd149797,  21'd139811,
        21'd131072, 21'd123362, 21'd116509,  21'd110377,
        21'd104858, 21'd99865,  21'd95326,   21'd91181,
        21'd87382,  21'd83887,  21'd80660,   21'd77673,
        21'd74899,  21'd72316,  21'd69906,   21'd67651
    };

    typedef struct packed {
        logic             valid;
        logic [1:0]       src;
        logic [TAP_W-1:0] tap;
    } t_tap_tag;

    typedef struct packed {
        logic                    busy;
        logic signed [SUM_W-1:0] sum_l;
        logic signed [SUM_W-1:0] sum_r;
    } t_echo_stat;

endpackage

// ===== src/stereo_multitap_echo_unit.sv =====
// Stereo multi-tap echo.
// Input channel: i_in_valid / o_in_ready carry one stereo frame (i_left_in, i_right_in)
// per beat. Output channel: o_out_valid / i_out_ready carry one frame of results per
// input beat, in order.
// Configuration channel: i_cfg_valid / o_cfg_ready write i_cfg_data to register
// i_cfg_index (0 spacing, 1 tap count, 2 alternate polarity, 3 linear divisor);
// other indexes are ignored. Write only while the block is idle.
// Each frame walks its taps through the history memory, one tap issued per cycle
// (a read only for taps within the fill), then a three-stage divide and accumulate
// pipeline drains before the result is formed and the frame is stored. A new frame
// is accepted only once the previous one is stored. The output register holds a
// finished beat, so a new frame is accepted while the receiver stalls; a second
// result waits until the held beat is taken. Reset clears the configuration and
// control registers to their defaults and empties the history logically: a fill
// count makes never-written entries read as zero, so no clearing pass is run.
module stereo_multitap_echo_unit #(
    parameter int HISTORY_DEPTH = smte_pkg::DEF_HISTORY_DEPTH,
    parameter int MAX_TAPS      = smte_pkg::DEF_MAX_TAPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [15:0]              i_left_in,
    input  logic signed [15:0]              i_right_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_left_out,
    output logic signed [15:0]              o_right_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [smte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [smte_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int TW = smte_pkg::TAP_W;
    localparam int DW = smte_pkg::DELAY_W;
    localparam int SW = smte_pkg::SAMPLE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [15:0]                  r_tap_spacing;
    logic [TW-1:0]                r_tap_count;
    logic                         r_alt;
    logic                         r_lin;
    logic [AW-1:0]                r_wp, n_wp;
    logic [FW-1:0]                r_fill, n_fill;
    logic [smte_pkg::FRAME_W-1:0] r_dry, n_dry;
    logic [TW-1:0]                r_taps, n_taps;
    logic [TW-1:0]                r_k, n_k;
    logic [DW-1:0]                r_delay, n_delay;
    logic                         r_out_valid;
    logic [SW-1:0]                r_left_out, r_right_out;

    logic                         in_acc;
    logic                         done_fire;
    logic [TW-1:0]                taps_sat;
    logic [AW:0]                  rd_diff;
    logic [AW:0]                  rd_wrap;
    logic                         mem_re;
    logic [smte_pkg::FRAME_W-1:0] mem_rdata;
    smte_pkg::t_tap_tag           tag;
    smte_pkg::t_echo_stat         stat;

    logic signed [smte_pkg::SUM_W-1:0] sum_sel [2];
    logic [1:0][SW-1:0]                sat;
    logic [1:0][SW:0]                  mix;
    logic [1:0][SW-1:0]                res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign taps_sat    = (r_tap_count > TW'(MAX_TAPS)) ? TW'(MAX_TAPS) : r_tap_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_spacing <= '0;
            r_tap_count   <= TW'(1);
            r_alt         <= 1'b0;
            r_lin         <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smte_pkg::CFG_TAP_SPACING:    r_tap_spacing <= i_cfg_data;
                smte_pkg::CFG_TAP_COUNT:      r_tap_count   <= i_cfg_data[TW-1:0];
                smte_pkg::CFG_ALTERNATE_POL:  r_alt         <= i_cfg_data[0];
                smte_pkg::CFG_LINEAR_DIVISOR: r_lin         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // tap issue: dry frame at zero delay, history within the fill, else zero
    always_comb begin
        tag.valid = (r_state == ST_RUN);
        tag.tap   = r_k;
        if (r_delay == '0) begin
            tag.src = smte_pkg::SRC_DRY;
        end else if (r_delay <= DW'(r_fill)) begin
            tag.src = smte_pkg::SRC_MEM;
        end else begin
            tag.src = smte_pkg::SRC_ZERO;
        end
        mem_re  = tag.valid && (tag.src == smte_pkg::SRC_MEM);
        rd_diff = {1'b0, r_wp} - r_delay[AW:0];
        rd_wrap = rd_diff[AW] ? (rd_diff + (AW+1)'(HISTORY_DEPTH)) : rd_diff;
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_delay   = r_delay;
        n_taps    = r_taps;
        n_dry     = r_dry;
        n_wp      = r_wp;
        n_fill    = r_fill;
        done_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_dry   = {i_right_in, i_left_in};
                    n_taps  = taps_sat;
                    n_k     = TW'(1);
                    n_delay = DW'(r_tap_spacing);
                    n_state = (taps_sat == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                n_k     = r_k + TW'(1);
                n_delay = r_delay + DW'(r_tap_spacing);
                if (r_k == r_taps) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    done_fire = 1'b1;
                    n_wp      = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                    if (r_fill != FW'(HISTORY_DEPTH)) begin
                        n_fill = r_fill + FW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_k     <= '0;
            r_taps  <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_k     <= n_k;
            r_taps  <= n_taps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dry   <= n_dry;
        r_delay <= n_delay;
    end

    // saturate the echo, mix with the dry sample and halve toward zero
    always_comb begin
        sum_sel[0] = stat.sum_l;
        sum_sel[1] = stat.sum_r;
        for (int ch = 0; ch < 2; ch++) begin
            if (sum_sel[ch] > smte_pkg::SUM_HI) begin
                sat[ch] = smte_pkg::SUM_HI[SW-1:0];
            end else if (sum_sel[ch] < smte_pkg::SUM_LO) begin
                sat[ch] = smte_pkg::SUM_LO[SW-1:0];
            end else begin
                sat[ch] = sum_sel[ch][SW-1:0];
            end
            mix[ch] = {r_dry[ch*SW + SW - 1], r_dry[ch*SW +: SW]} + {sat[ch][SW-1], sat[ch]};
            mix[ch] = mix[ch] + (SW+1)'(mix[ch][SW]);
            res[ch] = mix[ch][SW:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_left_out  <= res[0];
            r_right_out <= res[1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    smte_history_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (done_fire),
        .i_waddr (r_wp),
        .i_wdata (r_dry),
        .i_re    (mem_re),
        .i_raddr (rd_wrap[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    smte_tap_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (in_acc),
        .i_tag     (tag),
        .i_dry     (r_dry),
        .i_rd_data (mem_rdata),
        .i_alt     (r_alt),
        .i_lin     (r_lin),
        .o_stat    (stat)
    );

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !stat.busy)
        else $error("tap pipeline busy while accepting");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_re && done_fire))
        else $error("history read and write in the same cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("fill count beyond history depth");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> o_out_valid)
        else $error("finished beat not held in output register");
`endif

endmodule

// ===== src/smte_history_ram.sv =====
module smte_history_ram #(
    parameter int DEPTH = smte_pkg::DEF_HISTORY_DEPTH,
    parameter int AW    = $clog2(smte_pkg::DEF_HISTORY_DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [smte_pkg::FRAME_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [smte_pkg::FRAME_W-1:0] o_rdata
);

    logic [smte_pkg::FRAME_W-1:0] mem [DEPTH];
    logic [smte_pkg::FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/smte_tap_pipe.sv =====
module smte_tap_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  smte_pkg::t_tap_tag           i_tag,
    input  logic [smte_pkg::FRAME_W-1:0] i_dry,
    input  logic [smte_pkg::FRAME_W-1:0] i_rd_data,
    input  logic                         i_alt,
    input  logic                         i_lin,
    output smte_pkg::t_echo_stat         o_stat
);

    localparam int SW = smte_pkg::SAMPLE_W;
    localparam int PW = smte_pkg::SAMPLE_W + smte_pkg::RECIP_W;

    smte_pkg::t_tap_tag r_t1;

    logic                        r2_valid;
    logic [smte_pkg::TAP_W-1:0]  r2_tap;
    logic [1:0][SW-1:0]          r2_mag;
    logic [1:0]                  r2_sgn;

    logic                        r3_valid;
    logic [1:0][SW-1:0]          r3_q;
    logic [1:0]                  r3_sgn;

    logic signed [smte_pkg::SUM_W-1:0] r_sum_l;
    logic signed [smte_pkg::SUM_W-1:0] r_sum_r;

    logic [smte_pkg::FRAME_W-1:0] s1_frame;
    logic                         s1_neg;
    logic [SW-1:0]                s1_smp;
    logic [1:0][SW-1:0]           s1_mag;
    logic [1:0]                   s1_sgn;

    logic [smte_pkg::TAP_W-1:0]   s2_div;
    logic [smte_pkg::RECIP_W-1:0] s2_recip;
    logic [PW-1:0]                s2_prod;
    logic [1:0][SW-1:0]           s2_q;

    logic signed [smte_pkg::SUM_W-1:0] s3_term_l;
    logic signed [smte_pkg::SUM_W-1:0] s3_term_r;

    // select and rectify the tap sample
    always_comb begin
        case (r_t1.src)
            smte_pkg::SRC_DRY: s1_frame = i_dry;
            smte_pkg::SRC_MEM: s1_frame = i_rd_data;
            default:           s1_frame = '0;
        endcase
        s1_neg = i_alt & r_t1.tap[0];
        s1_smp = '0;
        for (int ch = 0; ch < 2; ch++) begin
            s1_smp     = s1_frame[ch*SW +: SW];
            s1_mag[ch] = s1_smp[SW-1] ? (~s1_smp + SW'(1)) : s1_smp;
            s1_sgn[ch] = s1_smp[SW-1] ^ s1_neg;
        end
    end

    // divide the magnitude by k+1 or 2^k
    always_comb begin
        s2_div   = r2_tap + smte_pkg::TAP_W'(1);
        s2_recip = smte_pkg::RECIP_TABLE[s2_div];
        s2_prod  = '0;
        for (int ch = 0; ch < 2; ch++) begin
            s2_prod  = PW'(r2_mag[ch]) * PW'(s2_recip);
            s2_q[ch] = i_lin ? s2_prod[smte_pkg::RECIP_SHIFT +: SW] : (r2_mag[ch] >> r2_tap);
        end
    end

    always_comb begin
        s3_term_l = $signed(smte_pkg::SUM_W'(r3_q[0]));
        s3_term_r = $signed(smte_pkg::SUM_W'(r3_q[1]));
        if (r3_sgn[0]) begin
            s3_term_l = -s3_term_l;
        end
        if (r3_sgn[1]) begin
            s3_term_r = -s3_term_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1     <= '0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r_t1     <= i_tag;
            r2_valid <= r_t1.valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_tap   <= r_t1.tap;
        r2_mag   <= s1_mag;
        r2_sgn   <= s1_sgn;
        r3_q     <= s2_q;
        r3_sgn   <= r2_sgn;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
        end else if (r3_valid) begin
            r_sum_l <= r_sum_l + s3_term_l;
            r_sum_r <= r_sum_r + s3_term_r;
        end
    end

    assign o_stat.busy  = r_t1.valid | r2_valid | r3_valid;
    assign o_stat.sum_l = r_sum_l;
    assign o_stat.sum_r = r_sum_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int HIST_DEPTH     = smte_pkg::DEF_HISTORY_DEPTH;
    localparam int TAP_LIMIT      = smte_pkg::DEF_MAX_TAPS;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_FRAMES  = 1150;
    localparam int FILL_FRAMES    = 200;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int MAX_REPORTS    = 40;
    localparam int CYCLE_LIMIT    = 3_000_000;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_echo_frame;

    logic                                i_clk;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    logic signed [15:0]                  i_left_in   = '0;
    logic signed [15:0]                  i_right_in  = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [15:0]                  o_left_out;
    logic signed [15:0]                  o_right_out;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [smte_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [smte_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;

    logic [31:0]  frame_store [HIST_DEPTH];
    int           write_slot;
    logic [15:0]  echo_spacing;
    logic [4:0]   echo_taps;
    logic         echo_alt;
    logic         echo_lin;

    t_echo_frame  echo_expected [$];

    bit  frame_offered  = 1'b0;
    bit  cfg_offered    = 1'b0;
    bit  in_idle_on     = 1'b1;
    bit  out_idle_on    = 1'b1;
    int  hold_off_req   = 0;
    int  stall_left     = 0;
    int  mismatches     = 0;
    int  frames_sent    = 0;
    int  results_checked = 0;
    int  settings_used  = 0;
    int  cycle_count    = 0;

    stereo_multitap_echo_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_echo_model();
        for (int i = 0; i < HIST_DEPTH; i++) frame_store[i] = '0;
        write_slot   = 0;
        echo_spacing = '0;
        echo_taps    = 5'd1;
        echo_alt     = 1'b0;
        echo_lin     = 1'b0;
    endfunction

    function automatic int clamp_sample(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Sum the taps, mix with the dry frame, then store the dry frame in the history.
    function automatic t_echo_frame mix_echo(input logic signed [15:0] dry_l,
                                             input logic signed [15:0] dry_r);
        int taps, delay, slot, divisor, tap_l, tap_r, sum_l, sum_r;
        t_echo_frame res;
        taps  = (echo_taps > TAP_LIMIT) ? TAP_LIMIT : int'(echo_taps);
        sum_l = 0;
        sum_r = 0;
        for (int k = 1; k <= taps; k++) begin
            delay = k * int'(echo_spacing);
            if (delay > HIST_DEPTH) continue;
            if (delay == 0) begin
                tap_l = dry_l;
                tap_r = dry_r;
            end else begin
                slot  = (write_slot + HIST_DEPTH - delay) % HIST_DEPTH;
                tap_l = $signed(frame_store[slot][15:0]);
                tap_r = $signed(frame_store[slot][31:16]);
            end
            if (echo_alt && k[0]) begin
                tap_l = -tap_l;
                tap_r = -tap_r;
            end
            divisor = echo_lin ? k + 1 : (1 << k);
            sum_l += tap_l / divisor;
            sum_r += tap_r / divisor;
        end
        res.left  = 16'((int'(dry_l) + clamp_sample(sum_l)) / 2);
        res.right = 16'((int'(dry_r) + clamp_sample(sum_r)) / 2);
        frame_store[write_slot] = {dry_r, dry_l};
        write_slot = (write_slot + 1) % HIST_DEPTH;
        return res;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            3: return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s (got %0d, expected %0d)",
                     $time, results_checked, what, got, want);
    endtask

    task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
        int gap;
        gap = (in_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            if (frame_offered) i_in_valid <= 1'b0;
            frame_offered = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_in     <= l;
        i_right_in    <= r;
        frame_offered = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        echo_expected.push_back(mix_echo(l, r));
        frames_sent++;
    endtask

    task automatic stop_frames();
        if (frame_offered) i_in_valid <= 1'b0;
        frame_offered = 1'b0;
    endtask

    task automatic drain_results();
        stop_frames();
        while (echo_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [smte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smte_pkg::CFG_DATA_W-1:0] data);
        if (!cfg_offered) i_cfg_valid <= 1'b1;
        cfg_offered = 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            smte_pkg::CFG_TAP_SPACING:    echo_spacing = data;
            smte_pkg::CFG_TAP_COUNT:      echo_taps    = data[4:0];
            smte_pkg::CFG_ALTERNATE_POL:  echo_alt     = data[0];
            smte_pkg::CFG_LINEAR_DIVISOR: echo_lin     = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] spacing, input logic [4:0] count,
                              input logic alt, input logic lin);
        logic [15:0] junk;
        drain_results();
        junk = 16'($urandom);
        write_reg(smte_pkg::CFG_TAP_SPACING, spacing);
        write_reg(smte_pkg::CFG_TAP_COUNT, {junk[15:5], count});
        write_reg(smte_pkg::CFG_ALTERNATE_POL, {junk[14:0], alt});
        write_reg(smte_pkg::CFG_LINEAR_DIVISOR, {junk[15:1], lin});
        i_cfg_valid <= 1'b0;
        cfg_offered = 1'b0;
        settings_used++;
    endtask

    task automatic test_default_config();
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h0000, 16'hffff);
        send_frame(16'h0001, 16'h8001);
    endtask

    task automatic test_zero_delay_taps();
        drain_results();
        set_config(16'd0, 5'd16, 1'b0, 1'b1);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'hffff, 16'h0001);
        set_config(16'd0, 5'd16, 1'b1, 1'b0);
        send_frame(16'h7fff, 16'h8000);
    endtask

    task automatic test_tap_count_limits();
        drain_results();
        set_config(16'd1, 5'd0, 1'b0, 1'b0);
        send_frame(rand_sample(), rand_sample());
        send_frame(16'h7fff, 16'h8000);
        set_config(16'd1, 5'd31, 1'b1, 1'b1);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h7fff, 16'h8000);
        set_config(16'd1, 5'd17, 1'b0, 1'b0);
        send_frame(rand_sample(), rand_sample());
    endtask

    task automatic test_history_taps();
        drain_results();
        set_config(16'd1, 5'd16, 1'b1, 1'b1);
        repeat (5) send_frame(rand_sample(), rand_sample());
    endtask

    task automatic test_delay_beyond_history();
        drain_results();
        set_config(16'hffff, 5'd3, 1'b0, 1'b0);
        send_frame(16'h7fff, 16'h8000);
        send_frame(rand_sample(), rand_sample());
        set_config(16'h8000, 5'd2, 1'b1, 1'b0);
        send_frame(16'h8000, 16'h7fff);
        send_frame(rand_sample(), rand_sample());
        set_config(16'd2048, 5'd16, 1'b0, 1'b1);
        send_frame(rand_sample(), rand_sample());
    endtask

    task automatic test_unlisted_registers();
        drain_results();
        for (int idx = smte_pkg::CFG_LINEAR_DIVISOR + 1;
             idx < (1 << smte_pkg::CFG_IDX_W); idx++)
            write_reg(smte_pkg::CFG_IDX_W'(idx), smte_pkg::CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        cfg_offered = 1'b0;
        send_frame(rand_sample(), rand_sample());
        send_frame(rand_sample(), rand_sample());
    endtask

    task automatic test_random_frames();
        int done, seg;
        logic [15:0] spacing;
        logic [4:0] count;
        done = 0;
        while (done < RANDOM_FRAMES) begin
            drain_results();
            case ($urandom_range(0, 7))
                0:       spacing = 16'd0;
                1, 2:    spacing = 16'($urandom_range(1, 4));
                3:       spacing = 16'($urandom_range(5, 64));
                4:       spacing = 16'($urandom_range(65, 700));
                5:       spacing = 16'($urandom);
                6:       spacing = 16'(HIST_DEPTH);
                default: spacing = 16'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 9) < 8) count = 5'($urandom_range(1, TAP_LIMIT));
            else count = 5'($urandom_range(0, 31));
            set_config(spacing, count, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            seg = $urandom_range(40, 160);
            repeat (seg) send_frame(rand_sample(), rand_sample());
            done += seg;
        end
    endtask

    task automatic test_output_hold_off();
        drain_results();
        set_config(16'd2, 5'd16, 1'b0, 1'b0);
        in_idle_on   = 1'b0;
        hold_off_req = HOLD_OFF_LEN;
        repeat (16) send_frame(rand_sample(), rand_sample());
    endtask

    task automatic test_sender_pause();
        drain_results();
        set_config(16'd5, 5'd8, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        repeat (25) send_frame(rand_sample(), rand_sample());
        drain_results();
        repeat (25) send_frame(rand_sample(), rand_sample());
    endtask

    task automatic test_fill_boundary();
        drain_results();
        set_config(16'd120, 5'd16, 1'b1, 1'b0);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (FILL_FRAMES) send_frame(rand_sample(), rand_sample());
    endtask

    // Receiver: random stalls, or a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                i_out_ready <= 1'b0;
                for (int held = 0; held < hold_off_req; held++) @(posedge i_clk);
                hold_off_req = 0;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (out_idle_on && $urandom_range(0, 99) < 15) begin
                i_out_ready <= 1'b0;
                stall_left = idle_len() - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_echo_frame want;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (echo_expected.size() == 0) begin
                    report_mismatch("beat with no frame pending, left", o_left_out, 0);
                end else begin
                    want = echo_expected.pop_front();
                    if (o_left_out !== want.left)
                        report_mismatch("left_out", o_left_out, want.left);
                    if (o_right_out !== want.right)
                        report_mismatch("right_out", o_right_out, want.right);
                end
                results_checked++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d beats outstanding",
                 cycle_count, echo_expected.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        clear_echo_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_zero_delay_taps();
        test_tap_count_limits();
        test_history_taps();
        test_delay_beyond_history();
        test_unlisted_registers();
        test_output_hold_off();
        test_sender_pause();
        test_random_frames();
        test_fill_boundary();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d frames, checked %0d results over %0d register settings.",
                 frames_sent, results_checked, settings_used);
        $display("Included tap counts 0 to 31, out-of-range delays, output hold-off %s",
                 "and taps crossing the filled part of the history.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
